@@ rtl/pps_eq_pkg.sv @@
package pps_eq_pkg;

	// Free-running counter rate in Hz
	localparam longint unsigned COUNTER_HZ = 64'd100000000;

	localparam longint unsigned NS_PER_S = 64'd1000000000;
	localparam longint unsigned US_PER_S = 64'd1000000;
	localparam longint unsigned MS_PER_S = 64'd1000;
	localparam longint unsigned SILENCE_S = 64'd3;

	// APB port
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	// Field widths
	localparam int DLY_W = 10;
	localparam int TOL_W = 17;
	localparam int TMO_W = 16;
	localparam int TOLP_W = 27;
	localparam int LIM_W = 36;

	// ns -> ticks: floor(rx * HZ / 1e9) as rx * DELAY_MUL >> DELAY_SHIFT, exact for 10-bit rx
	localparam int DELAY_SHIFT = 40;
	localparam int DPROD_W = DELAY_SHIFT + DLY_W + 1;
	localparam logic [127:0] DELAY_MUL_WIDE =
		((128'(COUNTER_HZ) << DELAY_SHIFT) + 128'(NS_PER_S - 64'd1)) / 128'(NS_PER_S);
	localparam logic [DELAY_SHIFT:0] DELAY_MUL = DELAY_MUL_WIDE[DELAY_SHIFT:0];

	localparam logic [9:0] TOL_MUL = 10'(COUNTER_HZ / US_PER_S);
	localparam logic [19:0] TMO_MUL = 20'(COUNTER_HZ / MS_PER_S);
	localparam logic [31:0] HZ_TICKS = 32'(COUNTER_HZ);
	localparam logic [31:0] SILENCE_TICKS = 32'(COUNTER_HZ * SILENCE_S);

	typedef logic [31:0] word_t;
	typedef logic [DLY_W-1:0] dly_t;
	typedef logic [TOL_W-1:0] tol_t;
	typedef logic [TMO_W-1:0] tmo_t;
	typedef logic [LIM_W-1:0] lim_t;

	typedef enum logic [0:0] {
		OP_EDGE = 1'b0,
		OP_TICK = 1'b1
	} op_e;

	typedef enum logic [1:0] {
		REG_RX_DELAY = 2'd0,
		REG_EDGE_TOL = 2'd1,
		REG_INFO_TMO = 2'd2
	} reg_idx_e;

	typedef struct packed {
		dly_t rx_delay_ns;
		tol_t edge_tolerance_us;
		tmo_t info_timeout_ms;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{rx_delay_ns: 10'd60, edge_tolerance_us: 17'd100,
		info_timeout_ms: 16'd500};

	// Thresholds in counter ticks, derived from the config registers
	typedef struct packed {
		dly_t delay;
		word_t win_lo;
		word_t win_hi;
		lim_t tmo_limit;
	} thr_t;

	typedef struct packed {
		logic published;
		word_t edge_time;
		word_t edge_width;
		logic width_valid;
		logic edge_pending;
		word_t edge_error_count;
		word_t edge_recv_count;
		word_t info_timeout_count;
	} res_t;

	function automatic thr_t derive_thr(cfg_t cfg);
		logic [DPROD_W-1:0] dprod;
		logic [TOLP_W-1:0] tol;
		word_t tol_w;
		thr_t r;
		dprod = DPROD_W'(cfg.rx_delay_ns) * DPROD_W'(DELAY_MUL);
		r.delay = dprod[DELAY_SHIFT +: DLY_W];
		tol = TOLP_W'(cfg.edge_tolerance_us) * TOLP_W'(TOL_MUL);
		tol_w = 32'(tol);
		// lower bound saturates at zero
		r.win_lo = (tol_w >= HZ_TICKS) ? '0 : HZ_TICKS - tol_w;
		r.win_hi = HZ_TICKS + tol_w;
		r.tmo_limit = LIM_W'(cfg.info_timeout_ms) * LIM_W'(TMO_MUL);
		return r;
	endfunction

endpackage

@@ rtl/pps_eq_if.sv @@
// Input item channel
interface pps_eq_in_if;
	logic valid;
	logic ready;
	pps_eq_pkg::op_e opcode;
	pps_eq_pkg::word_t capture_time;
	pps_eq_pkg::word_t now_time;
	logic info_ready;

	modport source (output valid, output opcode, output capture_time, output now_time,
		output info_ready, input ready);
	modport sink (input valid, input opcode, input capture_time, input now_time,
		input info_ready, output ready);
endinterface

// Result item channel
interface pps_eq_out_if;
	logic valid;
	logic ready;
	logic published;
	pps_eq_pkg::word_t edge_time;
	pps_eq_pkg::word_t edge_width;
	logic width_valid;
	logic edge_pending;
	pps_eq_pkg::word_t edge_error_count;
	pps_eq_pkg::word_t edge_recv_count;
	pps_eq_pkg::word_t info_timeout_count;

	modport source (output valid, output published, output edge_time, output edge_width,
		output width_valid, output edge_pending, output edge_error_count,
		output edge_recv_count, output info_timeout_count, input ready);
	modport sink (input valid, input published, input edge_time, input edge_width,
		input width_valid, input edge_pending, input edge_error_count,
		input edge_recv_count, input info_timeout_count, output ready);
endinterface

@@ rtl/pps_edge_qualifier_top.sv @@
// An accepted input transaction passes through the input register, then the result
// register, before its result is presented.
// Throughput: one transaction per cycle unless result.ready is low with a result held;
// the state update is subtract-and-compare logic between the input and result registers.
// Reset (arst_n low): edge state and tallies clear to zero, config registers return
// to their defaults; a transaction held in the input or result register is dropped.
module pps_edge_qualifier_top (
	input  logic clk,
	input  logic arst_n,
	pps_eq_in_if.sink item,
	pps_eq_out_if.source result,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [pps_eq_pkg::ADDR_W-1:0] paddr,
	input  logic [pps_eq_pkg::DATA_W-1:0] pwdata,
	output logic [pps_eq_pkg::DATA_W-1:0] prdata,
	output logic pready
);
	import pps_eq_pkg::*;

	thr_t thr;

	// Config registers and derived tick thresholds
	pps_eq_cfg u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.thr(thr)
	);

	// Edge qualification datapath
	pps_eq_core u_core (
		.clk(clk),
		.arst_n(arst_n),
		.thr(thr),
		.item(item),
		.result(result)
	);

endmodule

@@ rtl/pps_eq_cfg.sv @@
module pps_eq_cfg (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [pps_eq_pkg::ADDR_W-1:0] paddr,
	input  logic [pps_eq_pkg::DATA_W-1:0] pwdata,
	output logic [pps_eq_pkg::DATA_W-1:0] prdata,
	output logic pready,
	output pps_eq_pkg::thr_t thr
);
	import pps_eq_pkg::*;

	cfg_t cfg_q;
	thr_t thr_q;
	logic wr_en;
	reg_idx_e idx;

	assign pready = 1'b1;
	assign wr_en = psel & penable & pwrite;
	assign idx = reg_idx_e'(paddr[3:2]);

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (wr_en) begin
			unique case (idx)
				REG_RX_DELAY: cfg_q.rx_delay_ns <= pwdata[DLY_W-1:0];
				REG_EDGE_TOL: cfg_q.edge_tolerance_us <= pwdata[TOL_W-1:0];
				REG_INFO_TMO: cfg_q.info_timeout_ms <= pwdata[TMO_W-1:0];
				default: ;
			endcase
		end
	end

	// Tick thresholds, registered: they follow the config registers in the next cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= derive_thr(CFG_RESET);
		end else begin
			thr_q <= derive_thr(cfg_q);
		end
	end

	assign thr = thr_q;

	// Read back
	always_comb begin
		unique case (idx)
			REG_RX_DELAY: prdata = DATA_W'(cfg_q.rx_delay_ns);
			REG_EDGE_TOL: prdata = DATA_W'(cfg_q.edge_tolerance_us);
			REG_INFO_TMO: prdata = DATA_W'(cfg_q.info_timeout_ms);
			default: prdata = '0;
		endcase
	end

endmodule

@@ rtl/pps_eq_core.sv @@
module pps_eq_core (
	input  logic clk,
	input  logic arst_n,
	input  pps_eq_pkg::thr_t thr,
	pps_eq_in_if.sink item,
	pps_eq_out_if.source result
);
	import pps_eq_pkg::*;

	// Input register
	logic valid_s1;
	op_e opcode_s1;
	word_t capture_s1;
	word_t now_s1;
	logic info_ready_s1;

	// Qualifier state
	word_t last_edge_q;
	logic pending_q;
	word_t width_q;
	logic width_ok_q;
	word_t err_q;
	word_t recv_q;
	word_t tmo_q;

	// Result register
	logic out_valid_q;
	res_t out_q;

	logic advance;
	word_t edge_t;
	word_t diff;
	word_t since;
	logic in_win;
	res_t nxt;

	// Handshake: s1 drains into the result register when it is empty or being taken
	assign advance = valid_s1 & (~out_valid_q | result.ready);
	assign item.ready = ~valid_s1 | advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			opcode_s1 <= item.opcode;
			capture_s1 <= item.capture_time;
			now_s1 <= item.now_time;
			info_ready_s1 <= item.info_ready;
		end
	end

	// Interval checks, all modulo 2^32
	assign edge_t = capture_s1 - 32'(thr.delay);
	assign diff = edge_t - last_edge_q;
	assign since = now_s1 - last_edge_q;
	assign in_win = (diff > thr.win_lo) && (diff < thr.win_hi);

	// Next state, which is also the result
	always_comb begin
		nxt.published = 1'b0;
		nxt.edge_time = last_edge_q;
		nxt.edge_width = width_q;
		nxt.width_valid = width_ok_q;
		nxt.edge_pending = pending_q;
		nxt.edge_error_count = err_q;
		nxt.edge_recv_count = recv_q;
		nxt.info_timeout_count = tmo_q;
		unique case (opcode_s1)
			OP_EDGE: begin
				if (pending_q) begin
					if (in_win) begin
						nxt.edge_width = diff;
						nxt.width_valid = 1'b1;
					end else begin
						nxt.width_valid = 1'b0;
						nxt.edge_error_count = err_q + 32'd1;
					end
				end
				nxt.edge_time = edge_t;
				nxt.edge_pending = 1'b1;
				nxt.edge_recv_count = recv_q + 32'd1;
			end
			OP_TICK: begin
				if (pending_q) begin
					if (info_ready_s1) begin
						nxt.edge_pending = 1'b0;
						nxt.published = 1'b1;
					end else if (LIM_W'(since) > thr.tmo_limit) begin
						nxt.edge_pending = 1'b0;
						nxt.info_timeout_count = tmo_q + 32'd1;
					end
				end else if (width_ok_q && (since > SILENCE_TICKS)) begin
					nxt.width_valid = 1'b0;
				end
			end
			default: ;
		endcase
	end

	// State update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_edge_q <= '0;
			pending_q <= 1'b0;
			width_q <= '0;
			width_ok_q <= 1'b0;
			err_q <= '0;
			recv_q <= '0;
			tmo_q <= '0;
		end else if (advance) begin
			last_edge_q <= nxt.edge_time;
			pending_q <= nxt.edge_pending;
			width_q <= nxt.edge_width;
			width_ok_q <= nxt.width_valid;
			err_q <= nxt.edge_error_count;
			recv_q <= nxt.edge_recv_count;
			tmo_q <= nxt.info_timeout_count;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= nxt;
		end
	end

	assign result.valid = out_valid_q;
	assign result.published = out_q.published;
	assign result.edge_time = out_q.edge_time;
	assign result.edge_width = out_q.edge_width;
	assign result.width_valid = out_q.width_valid;
	assign result.edge_pending = out_q.edge_pending;
	assign result.edge_error_count = out_q.edge_error_count;
	assign result.edge_recv_count = out_q.edge_recv_count;
	assign result.info_timeout_count = out_q.info_timeout_count;

endmodule
